FILE: rtl/lir_pkg.sv
// shared widths, register map and controller/datapath interface types
`default_nettype none

package lir_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned PhaseW  = 32;
  localparam int unsigned StepW   = 37;
  localparam int unsigned SkipW   = 5;
  localparam int unsigned ChanW   = 2;
  localparam int unsigned AdvW    = 6;
  localparam int unsigned DataW   = 64;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DiffW   = SampleW + 1;
  localparam int unsigned ProdW   = DiffW + PhaseW + 1;
  localparam int unsigned NumW    = ProdW + 1;

  localparam int unsigned MaxRunDef = 16;

  // register select is paddr bit 3 (registers at byte 0 and byte 8)
  localparam logic RegChan = 1'b0;
  localparam logic RegStep = 1'b1;

  localparam logic [ChanW-1:0] ChanMono     = 2'd1;
  localparam logic [ChanW-1:0] ChanReset    = 2'd2;
  localparam logic [StepW-1:0] StepReset    = StepW'(64'h1_0000_0000);

  typedef struct packed {
    logic init;   // store frame, clear phase and skip count
    logic skip;   // store frame, count one skip down
    logic start;  // latch the new frame for a run
    logic mul;    // register the interpolation products
    logic emit;   // load one output frame and advance the phase
    logic last;   // this emit ends the run
  } cmd_t;

  typedef struct packed {
    logic primed;
    logic skip_zero;
    logic carry;
    logic out_free;
  } status_t;

endpackage : lir_pkg

`default_nettype wire

FILE: rtl/linear_interp_resampler.sv
// a restart, first, or skipped item is taken in the idle state and emits nothing
// a run item gives its output frames one at a time (product register, then sum and
// truncate into the output register, which waits while the output is stalled)
// an item holds the input for up to MAX_RUN output frames plus any output stall, set
// by the one multiplier pair; the next item is taken the cycle after the last loads
// reset: phase, skip count and stored frame cleared, stereo, step of 1.0
`default_nettype none

module linear_interp_resampler #(
  parameter int unsigned MAX_RUN = lir_pkg::MaxRunDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic        [lir_pkg::AddrW-1:0]    paddr,
  input  wire logic        [lir_pkg::DataW-1:0]    pwdata,
  output logic             [lir_pkg::DataW-1:0]    prdata,
  output logic                                     pready,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                restart_i,
  input  wire logic signed [lir_pkg::SampleW-1:0]  in_left_i,
  input  wire logic signed [lir_pkg::SampleW-1:0]  in_right_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed      [lir_pkg::SampleW-1:0]  out_left_o,
  output logic signed      [lir_pkg::SampleW-1:0]  out_right_o,
  output logic                                     run_last_o
);

  logic [lir_pkg::ChanW-1:0] chan;
  logic [lir_pkg::StepW-1:0] step;
  lir_pkg::cmd_t             cmd;
  lir_pkg::status_t          status;

  lir_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .chan_o    (chan),
    .step_o    (step)
  );

  lir_ctrl #(
    .MAX_RUN (MAX_RUN)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .restart_i  (restart_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lir_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .chan_i      (chan),
    .step_i      (step),
    .in_left_i   (in_left_i),
    .in_right_i  (in_right_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_left_o  (out_left_o),
    .out_right_o (out_right_o),
    .run_last_o  (run_last_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

endmodule : linear_interp_resampler

`default_nettype wire

FILE: rtl/lir_regs.sv
// configuration register file behind the apb-style port
`default_nettype none

module lir_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel_i,
  input  wire logic                        penable_i,
  input  wire logic                        pwrite_i,
  input  wire logic [lir_pkg::AddrW-1:0]   paddr_i,
  input  wire logic [lir_pkg::DataW-1:0]   pwdata_i,
  output logic      [lir_pkg::DataW-1:0]   prdata_o,
  output logic                             pready_o,
  output logic      [lir_pkg::ChanW-1:0]   chan_o,
  output logic      [lir_pkg::StepW-1:0]   step_o
);

  logic [lir_pkg::ChanW-1:0] chan_q;
  logic [lir_pkg::StepW-1:0] step_q;
  logic                      wr_en;
  logic                      reg_sel;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i & penable_i & pwrite_i;
  assign reg_sel  = paddr_i[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q <= lir_pkg::ChanReset;
      step_q <= lir_pkg::StepReset;
    end else if (wr_en) begin
      unique case (reg_sel)
        lir_pkg::RegChan: chan_q <= pwdata_i[lir_pkg::ChanW-1:0];
        lir_pkg::RegStep: step_q <= pwdata_i[lir_pkg::StepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      lir_pkg::RegChan: prdata_o = lir_pkg::DataW'(chan_q);
      lir_pkg::RegStep: prdata_o = lir_pkg::DataW'(step_q);
      default:          prdata_o = '0;
    endcase
  end

  assign chan_o = chan_q;
  assign step_o = step_q;

endmodule : lir_regs

`default_nettype wire

FILE: rtl/lir_ctrl.sv
// controller: input acceptance, run sequencing and run length count
`default_nettype none

module lir_ctrl #(
  parameter int unsigned MAX_RUN = lir_pkg::MaxRunDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             restart_i,
  input  wire lir_pkg::status_t status_i,
  output lir_pkg::cmd_t         cmd_o
);

  localparam int unsigned CntW = $clog2(MAX_RUN);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            at_limit;

  assign at_limit = (cnt_q == CntW'(MAX_RUN - 1));

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          priority if (restart_i || !status_i.primed) begin
            cmd_o.init = 1'b1;
          end else if (!status_i.skip_zero) begin
            cmd_o.skip = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            cnt_d       = '0;
            state_d     = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        // wait for the output register to drain
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = status_i.carry | at_limit;
          if (cmd_o.last) begin
            state_d = S_IDLE;
          end else begin
            cnt_d   = cnt_q + 1'b1;
            state_d = S_MUL;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_emit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> status_i.out_free)
    else $error("emit while output register occupied");

  a_last_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.last) |=> (state_q == S_IDLE))
    else $error("run did not end after last output");

  a_mul_origin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> ($past(cmd_o.start) || $past(cmd_o.emit && !cmd_o.last)))
    else $error("multiply step without start or prior output");

  a_run_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && at_limit) |-> cmd_o.last)
    else $error("run exceeded its length limit");

endmodule : lir_ctrl

`default_nettype wire

FILE: rtl/lir_dpath.sv
// datapath: frame store, phase accumulator, interpolation and output register
`default_nettype none

module lir_dpath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic        [lir_pkg::ChanW-1:0]    chan_i,
  input  wire logic        [lir_pkg::StepW-1:0]    step_i,
  input  wire logic signed [lir_pkg::SampleW-1:0]  in_left_i,
  input  wire logic signed [lir_pkg::SampleW-1:0]  in_right_i,
  input  wire lir_pkg::cmd_t                       cmd_i,
  output lir_pkg::status_t                         status_o,
  output logic signed      [lir_pkg::SampleW-1:0]  out_left_o,
  output logic signed      [lir_pkg::SampleW-1:0]  out_right_o,
  output logic                                     run_last_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i
);

  localparam int unsigned SampleW = lir_pkg::SampleW;
  localparam int unsigned PhaseW  = lir_pkg::PhaseW;
  localparam int unsigned AccW    = PhaseW + lir_pkg::AdvW;

  logic signed [SampleW-1:0]       prev_l_q, prev_r_q;
  logic signed [SampleW-1:0]       cur_l_q, cur_r_q;
  logic        [PhaseW-1:0]        phase_q;
  logic        [lir_pkg::SkipW-1:0] skip_q;
  logic                            primed_q;
  logic signed [lir_pkg::ProdW-1:0] prod_l_q, prod_r_q;
  logic signed [SampleW-1:0]       out_l_q, out_r_q;
  logic                            out_last_q;
  logic                            out_valid_q;

  logic signed [lir_pkg::DiffW-1:0] diff_l, diff_r;
  logic signed [PhaseW:0]           phase_s;
  logic signed [lir_pkg::ProdW-1:0] prod_l_d, prod_r_d;
  logic signed [lir_pkg::NumW-1:0]  num_l, num_r;
  logic signed [SampleW-1:0]        res_l, res_r;
  logic        [AccW-1:0]           acc;
  logic        [lir_pkg::AdvW-1:0]  adv;
  logic                             carry;
  logic                             out_free;
  logic                             mono;

  assign mono = (chan_i == lir_pkg::ChanMono);

  // (new - prev) * phase, phase taken as unsigned 0.32
  assign diff_l   = lir_pkg::DiffW'(cur_l_q) - lir_pkg::DiffW'(prev_l_q);
  assign diff_r   = lir_pkg::DiffW'(cur_r_q) - lir_pkg::DiffW'(prev_r_q);
  assign phase_s  = $signed({1'b0, phase_q});
  assign prod_l_d = lir_pkg::ProdW'(diff_l) * lir_pkg::ProdW'(phase_s);
  assign prod_r_d = lir_pkg::ProdW'(diff_r) * lir_pkg::ProdW'(phase_s);

  // prev * 2^32 + product, then divide by 2^32 rounding toward zero
  assign num_l = lir_pkg::NumW'($signed({prev_l_q, {PhaseW{1'b0}}}))
               + lir_pkg::NumW'(prod_l_q);
  assign num_r = lir_pkg::NumW'($signed({prev_r_q, {PhaseW{1'b0}}}))
               + lir_pkg::NumW'(prod_r_q);
  assign res_l = num_l[PhaseW +: SampleW]
               + SampleW'(num_l[lir_pkg::NumW-1] & (|num_l[PhaseW-1:0]));
  assign res_r = num_r[PhaseW +: SampleW]
               + SampleW'(num_r[lir_pkg::NumW-1] & (|num_r[PhaseW-1:0]));

  assign acc   = AccW'(phase_q) + AccW'(step_i);
  assign adv   = acc[AccW-1:PhaseW];
  assign carry = |adv;

  assign out_free = !out_valid_q || !out_stall_i;

  assign status_o.primed    = primed_q;
  assign status_o.skip_zero = (skip_q == '0);
  assign status_o.carry     = carry;
  assign status_o.out_free  = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q    <= 1'b0;
      phase_q     <= '0;
      skip_q      <= '0;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.init) begin
        primed_q <= 1'b1;
        phase_q  <= '0;
        skip_q   <= '0;
        prev_l_q <= in_left_i;
        prev_r_q <= in_right_i;
      end
      if (cmd_i.skip) begin
        skip_q   <= skip_q - 1'b1;
        prev_l_q <= in_left_i;
        prev_r_q <= in_right_i;
      end
      if (cmd_i.emit) begin
        phase_q <= acc[PhaseW-1:0];
        if (cmd_i.last) begin
          prev_l_q <= cur_l_q;
          prev_r_q <= cur_r_q;
          // a carry of k moves k frames: this one plus k-1 skipped
          skip_q   <= carry ? (adv[lir_pkg::SkipW-1:0] - 1'b1) : '0;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cur_l_q <= in_left_i;
      cur_r_q <= in_right_i;
    end
    if (cmd_i.mul) begin
      prod_l_q <= prod_l_d;
      prod_r_q <= prod_r_d;
    end
    if (cmd_i.emit) begin
      out_l_q    <= res_l;
      out_r_q    <= mono ? '0 : res_r;
      out_last_q <= cmd_i.last;
    end
  end

  assign out_left_o  = out_l_q;
  assign out_right_o = out_r_q;
  assign run_last_o  = out_last_q;
  assign out_valid_o = out_valid_q;

endmodule : lir_dpath

`default_nettype wire
